// ===== rtl/core/owbm_pkg.sv =====
// Shared types and constants for the 1-Wire block memory command engine.
package owbm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_HDR   = 4'd1,
    PH_WDATA = 4'd2,
    PH_RDATA = 4'd3,
    PH_BCRC  = 4'd4,
    PH_PROG  = 4'd5,
    PH_LIST  = 4'd6
  } phase_t;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BUS   = 2'd1;
  localparam logic [1:0] CMD_HOST  = 2'd2;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_PROT  = 3'd2;
  localparam logic [2:0] OP_RPROT = 3'd3;
  localparam logic [2:0] OP_CYC   = 3'd4;

  localparam logic [2:0] ACT_SEND    = 3'd0;
  localparam logic [2:0] ACT_READ    = 3'd1;
  localparam logic [2:0] ACT_WAIT    = 3'd2;
  localparam logic [2:0] ACT_RESET   = 3'd3;
  localparam logic [2:0] ACT_DELIVER = 3'd4;
  localparam logic [2:0] ACT_HOST    = 3'd5;
  localparam logic [2:0] ACT_DONE    = 3'd6;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_RANGE    = 4'd1;
  localparam logic [3:0] ST_CRC      = 4'd2;
  localparam logic [3:0] ST_PROT     = 4'd3;
  localparam logic [3:0] ST_EXHAUST  = 4'd4;
  localparam logic [3:0] ST_PROGERR  = 4'd5;
  localparam logic [3:0] ST_BADSTAT  = 4'd6;
  localparam logic [3:0] ST_BADPROT  = 4'd7;
  localparam logic [3:0] ST_BADCYC   = 4'd8;

  localparam logic [15:0] CRC_RESIDUE = 16'hB001;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] bus_byte;
    logic [3:0] status;
    logic       last;
  } res_t;

  // Up to four results for one input word, plus how many are valid.
  typedef struct packed {
    res_t [3:0] res;
    logic [2:0] count;
  } burst_t;

  function automatic logic [7:0] opcode_of(input logic [2:0] op);
    logic [7:0] v;
    case (op)
      OP_WRITE: v = 8'h55;
      OP_READ:  v = 8'hF0;
      OP_PROT:  v = 8'hC3;
      OP_RPROT: v = 8'hAA;
      default:  v = 8'hA5;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  function automatic res_t mk(input logic [2:0] a, input logic [7:0] b,
                              input logic [3:0] s);
    res_t r;
    r.action = a;
    r.bus_byte = b;
    r.status = s;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/owbm_if.sv =====
// Valid/ready channel interfaces for input, result and configuration words.
interface owbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [2:0] operation;
  logic [4:0] start_block;
  logic [4:0] block_count;
  logic [7:0] data_byte;
  modport source (output valid, command, operation, start_block, block_count, data_byte,
                  input ready);
  modport sink (input valid, command, operation, start_block, block_count, data_byte,
                output ready);
endinterface

interface owbm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] bus_byte;
  logic [3:0] status;
  logic       last;
  modport source (output valid, action, bus_byte, status, last, input ready);
  modport sink (input valid, action, bus_byte, status, last, output ready);
endinterface

interface owbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/owbm_front.sv =====
// Front end: accepts input words, steps the command sequencer, emits result bursts.
module owbm_front import owbm_pkg::*; #(
  parameter int TOTAL_BLOCKS = 31,
  parameter int BLOCK_BYTES  = 8,
  parameter int MAX_CYCLES   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [2:0] operation,
  input  logic [4:0] start_block,
  input  logic [4:0] block_count,
  input  logic [7:0] data_byte,
  input  logic [7:0] wait_ms,
  input  logic       q_full,
  output logic       q_push,
  output burst_t     q_data
);

  localparam int BIW = $clog2(BLOCK_BYTES + 1);

  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [4:0]  left_r, left_nxt;
  logic [BIW-1:0] idx_r, idx_nxt;
  burst_t      bo;

  assign in_ready = !q_full;

  // Step one word through the sequencer and build its burst.
  always_comb begin
    logic [15:0] c;
    logic [5:0]  sum;
    logic        bad;
    logic [4:0]  dec;
    logic [7:0]  v;
    phase_nxt = phase_r;
    crc_nxt = crc_r;
    op_nxt = op_r;
    left_nxt = left_r;
    idx_nxt = idx_r;
    bo = '0;
    c = crc_byte(crc_r, data_byte);
    sum = {1'b0, start_block} + {1'b0, block_count};
    dec = left_r - 5'd1;
    v = 8'h00;
    bad = 1'b0;
    if (command == CMD_START && phase_r == PH_IDLE) begin
      if (operation > OP_CYC) bad = 1'b1;
      else if (operation == OP_PROT) bad = 32'(start_block) >= TOTAL_BLOCKS;
      else bad = 32'(sum) > TOTAL_BLOCKS;
      if (bad) begin
        bo.res[0] = mk(ACT_DONE, 8'h00, ST_RANGE);
        bo.count = 3'd1;
      end else begin
        op_nxt = operation;
        left_nxt = (operation == OP_PROT) ? 5'd0 : block_count;
        crc_nxt = crc_byte(crc_byte(16'h0000, opcode_of(operation)), {3'b000, start_block});
        idx_nxt = '0;
        bo.res[0] = mk(ACT_SEND, opcode_of(operation), ST_OK);
        bo.res[1] = mk(ACT_SEND, {3'b000, start_block}, ST_OK);
        bo.res[2] = mk(ACT_READ, 8'h00, ST_OK);
        bo.count = 3'd3;
        phase_nxt = PH_HDR;
      end
    end else if (command == CMD_HOST && phase_r == PH_WDATA ||
                 command == CMD_BUS && phase_r == PH_RDATA) begin
      crc_nxt = c;
      bo.res[0] = mk((phase_r == PH_WDATA) ? ACT_SEND : ACT_DELIVER, data_byte, ST_OK);
      bo.count = 3'd2;
      if (32'(idx_r) + 1 < BLOCK_BYTES) begin
        idx_nxt = idx_r + BIW'(1);
        bo.res[1] = mk((phase_r == PH_WDATA) ? ACT_HOST : ACT_READ, 8'h00, ST_OK);
      end else begin
        idx_nxt = '0;
        bo.res[1] = mk(ACT_READ, 8'h00, ST_OK);
        phase_nxt = PH_BCRC;
      end
    end else if (command == CMD_BUS) begin
      unique case (phase_r)
        PH_HDR, PH_BCRC: begin
          crc_nxt = c;
          if (idx_r == '0) begin
            idx_nxt = BIW'(1);
            bo.res[0] = mk(ACT_READ, 8'h00, ST_OK);
            bo.count = 3'd1;
          end else begin
            idx_nxt = '0;
            if (c != CRC_RESIDUE) begin
              bo.res[0] = mk(ACT_RESET, 8'h00, ST_OK);
              bo.res[1] = mk(ACT_DONE, 8'h00, ST_CRC);
              bo.count = 3'd2;
              phase_nxt = PH_IDLE;
            end else if ((phase_r == PH_HDR && op_r == OP_PROT) ||
                         (phase_r == PH_BCRC && op_r == OP_WRITE)) begin
              bo.res[0] = mk(ACT_SEND, 8'hFF, ST_OK);
              bo.res[1] = mk(ACT_WAIT, wait_ms, ST_OK);
              bo.res[2] = mk(ACT_READ, 8'h00, ST_OK);
              bo.count = 3'd3;
              phase_nxt = PH_PROG;
            end else if ((phase_r == PH_HDR && left_r == 5'd0) ||
                         (phase_r == PH_BCRC && dec == 5'd0)) begin
              left_nxt = (phase_r == PH_BCRC) ? dec : left_r;
              bo.res[0] = mk(ACT_RESET, 8'h00, ST_OK);
              bo.res[1] = mk(ACT_DONE, 8'h00, ST_OK);
              bo.count = 3'd2;
              phase_nxt = PH_IDLE;
            end else if (op_r == OP_WRITE || op_r == OP_READ) begin
              left_nxt = (phase_r == PH_BCRC) ? dec : left_r;
              crc_nxt = '0;
              bo.res[0] = mk((op_r == OP_WRITE) ? ACT_HOST : ACT_READ, 8'h00, ST_OK);
              bo.count = 3'd1;
              phase_nxt = (op_r == OP_WRITE) ? PH_WDATA : PH_RDATA;
            end else begin
              bo.res[0] = mk(ACT_READ, 8'h00, ST_OK);
              bo.count = 3'd1;
              phase_nxt = PH_LIST;
            end
          end
        end
        PH_PROG: begin
          bo.res[0] = mk(ACT_RESET, 8'h00, ST_OK);
          bo.count = 3'd2;
          phase_nxt = PH_IDLE;
          if (data_byte == 8'h55) bo.res[1] = mk(ACT_DONE, 8'h00, ST_PROT);
          else if (data_byte == 8'hEE) bo.res[1] = mk(ACT_DONE, 8'h00, ST_PROGERR);
          else if (op_r == OP_WRITE) begin
            if (data_byte == 8'h33) bo.res[1] = mk(ACT_DONE, 8'h00, ST_EXHAUST);
            else if (data_byte[3:0] == 4'hA && 32'(data_byte[7:4]) < MAX_CYCLES) begin
              left_nxt = dec;
              if (dec == 5'd0) bo.res[1] = mk(ACT_DONE, 8'h00, ST_OK);
              else begin
                crc_nxt = '0;
                idx_nxt = '0;
                bo.res[0] = mk(ACT_HOST, 8'h00, ST_OK);
                bo.count = 3'd1;
                phase_nxt = PH_WDATA;
              end
            end else bo.res[1] = mk(ACT_DONE, 8'h00, ST_BADSTAT);
          end else begin
            bo.res[1] = mk(ACT_DONE, 8'h00, (data_byte == 8'h00) ? ST_OK : ST_BADSTAT);
          end
        end
        PH_LIST: begin
          if (op_r == OP_RPROT) begin
            bad = !(data_byte == 8'h0F || data_byte == 8'hF0);
            v = (data_byte == 8'hF0) ? 8'h01 : 8'h00;
          end else begin
            bad = 32'(data_byte) > MAX_CYCLES;
            v = data_byte;
          end
          if (bad) begin
            bo.res[0] = mk(ACT_RESET, 8'h00, ST_OK);
            bo.res[1] = mk(ACT_DONE, 8'h00, (op_r == OP_RPROT) ? ST_BADPROT : ST_BADCYC);
            bo.count = 3'd2;
            phase_nxt = PH_IDLE;
          end else begin
            left_nxt = dec;
            bo.res[0] = mk(ACT_DELIVER, v, ST_OK);
            if (dec == 5'd0) begin
              bo.res[1] = mk(ACT_RESET, 8'h00, ST_OK);
              bo.res[2] = mk(ACT_DONE, 8'h00, ST_OK);
              bo.count = 3'd3;
              phase_nxt = PH_IDLE;
            end else begin
              bo.res[1] = mk(ACT_READ, 8'h00, ST_OK);
              bo.count = 3'd2;
            end
          end
        end
        default: ;
      endcase
    end
    if (bo.count != 3'd0) bo.res[bo.count[1:0] - 2'd1].last = 1'b1;
  end

  assign q_push = in_valid && in_ready && bo.count != 3'd0;
  assign q_data = bo;

  // Advance the sequencer state on each accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      crc_r <= '0;
      op_r <= '0;
      left_r <= '0;
      idx_r <= '0;
    end else if (in_valid && in_ready) begin
      phase_r <= phase_nxt;
      crc_r <= crc_nxt;
      op_r <= op_nxt;
      left_r <= left_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== rtl/core/owbm_queue.sv =====
// Two-entry queue of result bursts between front and back end.
module owbm_queue import owbm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  burst_t push_data,
  output logic   full,
  output logic   nonempty,
  input  logic   pop,
  output burst_t head
);

  burst_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign head = mem_r[rp_r];

  // Store pushed bursts.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/owbm_back.sv =====
// Back end: unrolls each queued burst into result words on the output channel.
module owbm_back import owbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_nonempty,
  input  burst_t     q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  logic [1:0] sel_r;
  logic       fin;

  assign out_valid = q_nonempty;
  assign out_res = q_head.res[sel_r];
  assign fin = {1'b0, sel_r} + 3'd1 == q_head.count;
  assign q_pop = q_nonempty && out_ready && fin;

  // Step through the burst one word per handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) sel_r <= 2'd0;
    else if (q_nonempty && out_ready) sel_r <= fin ? 2'd0 : sel_r + 2'd1;
  end

endmodule

// ===== rtl/core/onewire_block_memory_command_engine.sv =====
// Top level of the 1-Wire block memory command engine.
// Usage:
//   in  : command words (start, bus byte received, host byte supplied).
//   out : bus actions for the host to carry out, in order; last marks the
//         final action caused by one input word.
//   cfg : one 8-bit register, the programming wait in ms (reset 20).
// An input word is taken every cycle while the result queue has room; its
// one to three results enter a two-burst queue in the same cycle. The first
// result appears on out once its burst is stored in the queue and earlier
// bursts have been sent, and then one per cycle while out_ready is high; a
// burst of n results takes n handshakes of the output port, which sets the
// sustained rate. Words that cause no result do not enter the queue.
// A stall on out fills the queue; in_ready drops once both entries are used
// and no word is lost. Reset (rst_n low, synchronous) empties the queue and
// returns the sequencer to idle with a zero CRC.
module onewire_block_memory_command_engine import owbm_pkg::*; #(
  parameter int TOTAL_BLOCKS = 31,
  parameter int BLOCK_BYTES  = 8,
  parameter int MAX_CYCLES   = 8
) (
  input  logic clk,
  input  logic rst_n,
  owbm_in_if.sink    in_ch,
  owbm_out_if.source out_ch,
  owbm_cfg_if.sink   cfg_ch
);

  logic [7:0] wait_r;
  logic       q_full, q_push, q_ne, q_pop;
  burst_t     q_in, q_head;
  res_t       r;

  assign cfg_ch.ready = 1'b1;

  // Hold the wait register.
  always_ff @(posedge clk) begin
    if (!rst_n) wait_r <= 8'd20;
    else if (cfg_ch.valid) wait_r <= cfg_ch.data;
  end

  owbm_front #(.TOTAL_BLOCKS(TOTAL_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES),
               .MAX_CYCLES(MAX_CYCLES)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .command(in_ch.command), .operation(in_ch.operation),
    .start_block(in_ch.start_block), .block_count(in_ch.block_count),
    .data_byte(in_ch.data_byte), .wait_ms(wait_r),
    .q_full, .q_push, .q_data(q_in)
  );

  owbm_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .nonempty(q_ne), .pop(q_pop), .head(q_head)
  );

  owbm_back u_back (
    .clk, .rst_n, .q_nonempty(q_ne), .q_head, .q_pop,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(r)
  );

  assign out_ch.action = r.action;
  assign out_ch.bus_byte = r.bus_byte;
  assign out_ch.status = r.status;
  assign out_ch.last = r.last;

endmodule
